/* src/amdf_semi_period_finder_top_macros.svh */
// ----------------------------------------------------------------------------
// AMDF semi-period finder assertion macros
// Shared property shorthands for the finder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef AMDF_SEMI_PERIOD_FINDER_TOP_MACROS_SVH
`define AMDF_SEMI_PERIOD_FINDER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AMDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AMDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/amdf_pkg.sv */
// ----------------------------------------------------------------------------
// AMDF package
// Widths, constants, shared types and the margin helper of the finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amdf_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SAMPLE_W    = 16;
   localparam int LAG_W       = ADDR_W;
   localparam int SUM_W       = 28;
   localparam int PROD_W      = SUM_W + CNT_W;
   localparam int SEMI_W      = 13;

   // floor(n/10) as (n * 6554) >> 16, exact for n up to MAX_SAMPLES
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(6554);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_START,
      ST_SUM,
      ST_MUL,
      ST_CMP,
      ST_EMIT
   } state_type;

   // sample memory write port
   typedef struct packed {
      logic                       en;
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } wr_type;

   // lag-sum command
   typedef struct packed {
      logic             start;
      logic [LAG_W-1:0] lag;
      logic [CNT_W-1:0] count;
   } sum_cmd_type;

   // lag-sum status
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] sum;
   } sum_status_type;

   function automatic logic [LAG_W-1:0] margin(input logic [CNT_W-1:0] n);
      logic [CNT_W+RECIP_W-1:0] prod;
      prod = (CNT_W+RECIP_W)'(n) * (CNT_W+RECIP_W)'(RECIP_TEN);
      return LAG_W'(prod >> RECIP_SHIFT);
   endfunction

endpackage

/* src/amdf_lag_sum.sv */
// ----------------------------------------------------------------------------
// AMDF lag sum unit
// Holds the sample memory and forms S(p) = sum |x[t+p] - x[t]| over t < n-p,
// one term per cycle through a read / difference / accumulate pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amdf_lag_sum (
   input  logic                    clock,
   input  logic                    reset,
   input  amdf_pkg::wr_type        wr,
   input  amdf_pkg::sum_cmd_type   cmd,
   output amdf_pkg::sum_status_type status
);
   import amdf_pkg::*;

   // sample memory, two read ports
   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [CNT_W-1:0]           t_ff, t_in;
   logic [CNT_W-1:0]           lim_ff, lim_in;
   logic [LAG_W-1:0]           lag_ff, lag_in;
   logic                       issue_ff, issue_in;
   logic                       busy_ff, busy_in;
   logic                       v1_ff, v2_ff;
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic [SAMPLE_W-1:0]        diff_ff, diff_in;
   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [ADDR_W-1:0]          addr_a, addr_b;
   logic signed [SAMPLE_W:0]   delta;
   logic                       done;

   // write loads, reads follow the issue counter
   assign addr_b = t_ff[ADDR_W-1:0];
   assign addr_a = t_ff[ADDR_W-1:0] + lag_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // advance the issue counter
   always_comb begin
      t_in     = t_ff;
      lim_in   = lim_ff;
      lag_in   = lag_ff;
      issue_in = issue_ff;
      busy_in  = busy_ff;
      if (cmd.start) begin
         t_in     = '0;
         lim_in   = cmd.count - CNT_W'(cmd.lag);
         lag_in   = cmd.lag;
         issue_in = 1'b1;
         busy_in  = 1'b1;
      end else begin
         if (issue_ff) begin
            t_in = t_ff + CNT_W'(1);
            if (t_in == lim_ff) begin
               issue_in = 1'b0;
            end
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   // absolute difference and accumulate
   assign delta   = (SAMPLE_W+1)'(rd_a_ff) - (SAMPLE_W+1)'(rd_b_ff);
   assign diff_in = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : SAMPLE_W'(delta);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + SUM_W'(diff_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         busy_ff  <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         busy_ff  <= busy_in;
         v1_ff    <= issue_ff;
         v2_ff    <= v1_ff;
      end
      t_ff    <= t_in;
      lim_ff  <= lim_in;
      lag_ff  <= lag_in;
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
   end

   assign done        = busy_ff & ~issue_ff & ~v1_ff & ~v2_ff;
   assign status.busy = busy_ff;
   assign status.done = done;
   assign status.sum  = acc_ff;

endmodule

/* src/amdf_semi_period_finder_top.sv */
// ----------------------------------------------------------------------------
// AMDF semi-period finder
// Loads a sample set, then searches lags in [n/10, n - n/10) for the
// smallest nonzero average magnitude difference, compared by cross-product.
// ----------------------------------------------------------------------------
//
//   channel | ports                                | moves
//   --------+--------------------------------------+---------------------------
//   req     | req_valid, req_ready, req_sample,    | one sample, last marks end
//           | req_last                             |
//   rsp     | rsp_valid, rsp_ready, rsp_half_period| chosen lag or -1
//
// Samples load one per cycle into the sample memory while req_ready is high.
// After the last request the search runs with req_ready low: each lag p is
// summed with one memory read pair per term of the lag sum.
// The result sits in an output register; a new set may load while it waits.
// A finished search holds in emit while an earlier response is still waiting.
// Reset clears the state, the sample count, the best lag and sum, and the response valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "amdf_semi_period_finder_top_macros.svh"

module amdf_semi_period_finder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [amdf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [amdf_pkg::SEMI_W-1:0]   rsp_half_period
);
   import amdf_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LAG_W-1:0]      l_ff, l_in;
   logic [LAG_W-1:0]      p_ff, p_in;
   logic                  first_ff, first_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      best_sum_ff, best_sum_in;
   logic [LAG_W-1:0]      best_lag_ff, best_lag_in;
   logic [PROD_W-1:0]     prod_a_ff, prod_b_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SEMI_W-1:0]     rsp_semi_ff, rsp_semi_in;
   logic                  accept;
   logic                  more;
   logic                  better;
   wr_type                wr;
   sum_cmd_type           cmd;
   sum_status_type        status;

   amdf_lag_sum u_lag_sum (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .cmd    (cmd),
      .status (status)
   );

   assign accept = req_valid & req_ready;
   // another lag remains inside the window
   assign more   = ((CNT_W+1)'(p_ff) + (CNT_W+1)'(1) + (CNT_W+1)'(l_ff))
                   < (CNT_W+1)'(count_ff);
   assign better = first_ff | ((sum_ff != '0) & (prod_a_ff < prod_b_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (accept && req_last) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_START;
         ST_START: state_in = ST_SUM;
         ST_SUM:   if (status.done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_CMP;
         ST_CMP:   state_in = more ? ST_START : ST_EMIT;
         ST_EMIT:  if (!rsp_valid_ff) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // state outputs and lag-sum command
   always_comb begin
      req_ready = 1'b0;
      cmd.start = 1'b0;
      cmd.lag   = p_ff;
      cmd.count = count_ff;
      case (state_ff)
         ST_LOAD:  req_ready = 1'b1;
         ST_START: cmd.start = 1'b1;
         default: begin
            req_ready = 1'b0;
            cmd.start = 1'b0;
         end
      endcase
   end

   // store a sample unless the memory is full
   assign wr.en   = accept && (count_ff < CNT_W'(MAX_SAMPLES));
   assign wr.addr = count_ff[ADDR_W-1:0];
   assign wr.data = req_sample;

   // datapath updates
   always_comb begin
      count_in     = count_ff;
      l_in         = l_ff;
      p_in         = p_ff;
      first_in     = first_ff;
      sum_in       = sum_ff;
      best_sum_in  = best_sum_ff;
      best_lag_in  = best_lag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_semi_in  = rsp_semi_ff;
      if (wr.en) begin
         count_in = count_ff + CNT_W'(1);
      end
      case (state_ff)
         ST_SETUP: begin
            l_in     = margin(count_ff);
            p_in     = margin(count_ff);
            first_in = 1'b1;
         end
         ST_SUM: begin
            if (status.done) begin
               sum_in = status.sum;
            end
         end
         ST_CMP: begin
            first_in = 1'b0;
            if (better) begin
               best_sum_in = sum_ff;
               best_lag_in = p_ff;
            end
            if (more) begin
               p_in = p_ff + LAG_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_semi_in  = (best_sum_ff != '0) ? SEMI_W'(best_lag_ff) : '1;
               count_in     = '0;
            end
         end
         default: begin
            count_in = count_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         best_sum_ff  <= '0;
         best_lag_ff  <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_sum_ff  <= best_sum_in;
         best_lag_ff  <= best_lag_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      l_ff        <= l_in;
      p_ff        <= p_in;
      sum_ff      <= sum_in;
      rsp_semi_ff <= rsp_semi_in;
      // cross-multiply the averages
      prod_a_ff   <= PROD_W'(sum_ff) * PROD_W'(count_ff - CNT_W'(best_lag_ff));
      prod_b_ff   <= PROD_W'(best_sum_ff) * PROD_W'(count_ff - CNT_W'(p_ff));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_half_period = rsp_semi_ff;

   `AMDF_ASSERT_NOW(a_ready_idle, clock, reset, req_ready, !status.busy, "load during search")
   `AMDF_ASSERT_NOW(a_done_in_sum, clock, reset, status.done, state_ff == ST_SUM, "stray done")
   `AMDF_ASSERT_NOW(a_lag_window, clock, reset, state_ff == ST_CMP,
                    (CNT_W+1)'(p_ff) + (CNT_W+1)'(l_ff) < (CNT_W+1)'(count_ff),
                    "lag out of window")
   `AMDF_ASSERT_NEXT(a_emit, clock, reset, state_ff == ST_EMIT && !rsp_valid_ff,
                     rsp_valid_ff, "lost result")

endmodule
